@@ src/fkvc_pkg.sv @@
// ----------------------------------------------------------------------------
// fkvc_pkg
// Shared sizes, status codes and types of the fifo replacement key value cache.
// ----------------------------------------------------------------------------
package fkvc_pkg;

   localparam int ENTRIES   = 64;
   localparam int KEY_BITS  = 64;
   localparam int DATA_BITS = 64;

   localparam int SLOT_BITS  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int COUNT_BITS = $clog2(ENTRIES + 1);
   localparam int CAP_BITS   = 7;
   localparam int CMP_BITS   = (COUNT_BITS > CAP_BITS) ? COUNT_BITS : CAP_BITS;

   localparam logic [CAP_BITS-1:0] CAPACITY_RESET = CAP_BITS'(64);

   typedef enum logic [2:0] {
      ST_HIT         = 3'd0,
      ST_MISS        = 3'd1,
      ST_NEW         = 3'd2,
      ST_OVERWRITTEN = 3'd3,
      ST_EXISTS      = 3'd4,
      ST_NO_ROOM     = 3'd5
   } status_type;

   typedef enum logic {
      CMD_FETCH = 1'b0,
      CMD_STORE = 1'b1
   } cmd_type;

endpackage

@@ src/fifo_replacement_key_value_cache_top.sv @@
// ----------------------------------------------------------------------------
// fifo_replacement_key_value_cache_top
// Fully associative key/data cache, exact key match, oldest-first eviction.
// ----------------------------------------------------------------------------
// response: a word taken into the input register passes the result register and
//   shows on the rsp_ ports for one cycle under rsp_strobe
// throughput: one word per cycle; busy stays low, the key compare over all
//   slots and the age list update fit between the input and result registers
// reset: clears fill count, strobes and capacity (back to 64); key, data and
//   age list storage keeps its contents and is only read below the fill count
module fifo_replacement_key_value_cache_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [0:0]  req_cmd,
   input  logic [63:0] req_key,
   input  logic [63:0] req_data_in,
   input  logic [0:0]  req_overwrite,
   output logic        rsp_strobe,
   output logic [2:0]  rsp_status,
   output logic [0:0]  rsp_success,
   output logic [63:0] rsp_data_out,
   output logic [0:0]  rsp_evicted,
   output logic [6:0]  rsp_entries_used,
   input  logic        csr_wr_en,
   input  logic [6:0]  csr_wr_data
);

   localparam int N  = fkvc_pkg::ENTRIES;
   localparam int SB = fkvc_pkg::SLOT_BITS;
   localparam int CB = fkvc_pkg::COUNT_BITS;
   localparam int KB = fkvc_pkg::KEY_BITS;
   localparam int DB = fkvc_pkg::DATA_BITS;
   localparam int MB = fkvc_pkg::CMP_BITS;

   // configuration
   logic [fkvc_pkg::CAP_BITS-1:0] capacity_ff;

   // input register
   logic                  req_valid_ff;
   fkvc_pkg::cmd_type     req_cmd_ff;
   logic [KB-1:0]         req_key_ff;
   logic [DB-1:0]         req_data_ff;
   logic                  req_ovw_ff;

   // cache state
   logic [KB-1:0]         slot_key_ff   [N];
   logic [SB-1:0]         order_ff      [N];
   logic [SB-1:0]         order_in      [N];
   logic [DB-1:0]         slot_data_mem [N];
   logic [CB-1:0]         fill_ff;
   logic [CB-1:0]         fill_in;

   // result register
   logic                  rsp_valid_ff;
   fkvc_pkg::status_type  rsp_status_ff;
   fkvc_pkg::status_type  status_in;
   logic                  rsp_success_ff;
   logic                  success_in;
   logic                  rsp_evicted_ff;
   logic                  evicted_in;
   logic                  rsp_hit_ff;
   logic [CB-1:0]         rsp_entries_ff;
   logic [DB-1:0]         rd_data_ff;

   // lookup and update control
   logic [N-1:0]          valid_vec;
   logic [N-1:0]          hit_vec;
   logic                  hit;
   logic [SB-1:0]         hit_slot;
   logic [SB-1:0]         hit_pos;
   logic [MB-1:0]         limit;
   logic [MB-1:0]         fill_ext;
   logic                  has_room;
   logic                  key_we;
   logic                  data_we;
   logic                  order_shift;
   logic                  order_append;
   logic [SB-1:0]         rm_pos;
   logic [SB-1:0]         wr_slot;
   logic [CB-1:0]         append_pos;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= fkvc_pkg::CAPACITY_RESET;
      end else if (csr_wr_en) begin
         capacity_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= start;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         req_cmd_ff  <= fkvc_pkg::cmd_type'(req_cmd);
         req_key_ff  <= req_key[KB-1:0];
         req_data_ff <= req_data_in[DB-1:0];
         req_ovw_ff  <= req_overwrite[0];
      end
   end

   // parallel compare against every filled slot
   always_comb begin
      hit_slot = '0;
      hit_pos  = '0;
      for (int i = 0; i < N; i++) begin
         valid_vec[i] = CB'(i) < fill_ff;
         hit_vec[i]   = valid_vec[i] && (slot_key_ff[i] == req_key_ff);
         if (hit_vec[i]) begin
            hit_slot = hit_slot | SB'(i);
         end
      end
      hit = |hit_vec;
      for (int i = 0; i < N; i++) begin
         if (valid_vec[i] && (order_ff[i] == hit_slot)) begin
            hit_pos = hit_pos | SB'(i);
         end
      end
   end

   assign fill_ext = MB'(fill_ff);
   assign limit    = (MB'(capacity_ff) > MB'(N)) ? MB'(N) : MB'(capacity_ff);
   assign has_room = fill_ext < limit;

   always_comb begin
      status_in    = fkvc_pkg::ST_MISS;
      success_in   = 1'b0;
      evicted_in   = 1'b0;
      fill_in      = fill_ff;
      key_we       = 1'b0;
      data_we      = 1'b0;
      order_shift  = 1'b0;
      order_append = 1'b0;
      rm_pos       = '0;
      wr_slot      = hit_slot;
      if (req_cmd_ff == fkvc_pkg::CMD_FETCH) begin
         if (hit) begin
            status_in  = fkvc_pkg::ST_HIT;
            success_in = 1'b1;
         end
      end else if (hit) begin
         if (req_ovw_ff) begin
            // move the entry to the newest end of the age list
            status_in    = fkvc_pkg::ST_OVERWRITTEN;
            success_in   = 1'b1;
            data_we      = 1'b1;
            order_shift  = 1'b1;
            order_append = 1'b1;
            rm_pos       = hit_pos;
         end else begin
            status_in = fkvc_pkg::ST_EXISTS;
         end
      end else if (has_room) begin
         status_in    = fkvc_pkg::ST_NEW;
         success_in   = 1'b1;
         key_we       = 1'b1;
         data_we      = 1'b1;
         order_append = 1'b1;
         wr_slot      = SB'(fill_ff);
         fill_in      = fill_ff + CB'(1);
      end else if (fill_ff == '0) begin
         status_in = fkvc_pkg::ST_NO_ROOM;
      end else begin
         // reuse the slot of the oldest entry
         status_in    = fkvc_pkg::ST_NEW;
         success_in   = 1'b1;
         evicted_in   = 1'b1;
         key_we       = 1'b1;
         data_we      = 1'b1;
         order_shift  = 1'b1;
         order_append = 1'b1;
         wr_slot      = order_ff[0];
      end
   end

   assign append_pos = fill_in - CB'(1);

   always_comb begin
      for (int i = 0; i < N; i++) begin
         order_in[i] = order_ff[i];
         if (order_shift && (SB'(i) >= rm_pos) && (i + 1 < N)) begin
            order_in[i] = order_ff[(i + 1) % N];
         end
         if (order_append && (CB'(i) == append_pos)) begin
            order_in[i] = wr_slot;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else if (req_valid_ff) begin
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid_ff) begin
         for (int i = 0; i < N; i++) begin
            order_ff[i] <= order_in[i];
         end
         if (key_we) begin
            slot_key_ff[wr_slot] <= req_key_ff;
         end
      end
   end

   // data store: one write port, one registered read port at the hit slot
   always_ff @(posedge clock) begin
      if (req_valid_ff && data_we) begin
         slot_data_mem[wr_slot] <= req_data_ff;
      end
      rd_data_ff <= slot_data_mem[hit_slot];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid_ff) begin
         rsp_status_ff  <= status_in;
         rsp_success_ff <= success_in;
         rsp_evicted_ff <= evicted_in;
         rsp_hit_ff     <= (status_in == fkvc_pkg::ST_HIT);
         rsp_entries_ff <= fill_in;
      end
   end

   assign rsp_strobe       = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_success      = rsp_success_ff;
   assign rsp_evicted      = rsp_evicted_ff;
   assign rsp_entries_used = 7'(rsp_entries_ff);
   assign rsp_data_out     = rsp_hit_ff ? 64'(rd_data_ff) : '0;

endmodule

@@ src/fkvc_checker.sv @@
// ----------------------------------------------------------------------------
// fkvc_checker
// Port-level checks of the cache top level, attached by bind.
// ----------------------------------------------------------------------------
module fkvc_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        rsp_strobe,
   input logic [2:0]  rsp_status,
   input logic [0:0]  rsp_success,
   input logic [63:0] rsp_data_out,
   input logic [0:0]  rsp_evicted,
   input logic [6:0]  rsp_entries_used
);

   // every word taken gets its response strobe after the input and result registers
   a_latency: assert property (@(posedge clock) disable iff (reset)
      start |=> ##1 rsp_strobe)
      else $error("response missing two cycles after start");

   a_success: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_success[0]) |->
         (rsp_status == fkvc_pkg::ST_HIT || rsp_status == fkvc_pkg::ST_NEW ||
          rsp_status == fkvc_pkg::ST_OVERWRITTEN))
      else $error("success flag with a failing status");

   a_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data_out != '0) |-> rsp_status == fkvc_pkg::ST_HIT)
      else $error("data returned on a non-hit");

   a_evict: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_evicted[0]) |->
         (rsp_status == fkvc_pkg::ST_NEW &&
          rsp_entries_used != '0))
      else $error("eviction without a new-key store on a filled cache");

   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_entries_used <= 7'(fkvc_pkg::ENTRIES))
      else $error("entry count above slot count");

endmodule

bind fifo_replacement_key_value_cache_top fkvc_checker u_fkvc_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .rsp_strobe       (rsp_strobe),
   .rsp_status       (rsp_status),
   .rsp_success      (rsp_success),
   .rsp_data_out     (rsp_data_out),
   .rsp_evicted      (rsp_evicted),
   .rsp_entries_used (rsp_entries_used)
);
